FILE: rtl/core/ptzs_pkg.sv
// Shared types and constants of the pedestal tracker with zero suppression.
// No dependencies; used by every module of the block but ptzs_ram.
package ptzs_pkg;

   localparam int CHANNELS    = 256;
   localparam int CH_W        = $clog2(CHANNELS);
   localparam int PAGES       = 2 * CHANNELS;
   localparam int PAGE_W      = $clog2(PAGES);
   localparam int PAGE_LIMIT  = 10000;
   localparam int DIV_STEPS   = 64;
   localparam int SQRT_STEPS  = 24;
   localparam logic [47:0] M48 = {48{1'b1}};

   localparam logic [2:0] CSR_CUTOFF_ADDR = 3'd0;
   localparam logic [15:0] CUTOFF_RESET   = 16'd768;

   typedef struct packed {
      logic [15:0] count;
      logic [31:0] mean;
      logic [63:0] m2;
      logic [47:0] variance;
   } page_type;

   localparam int PAGE_BITS = $bits(page_type);

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic rd;
      logic cap0;
      logic cap1;
      logic upd;
      logic div_step;
      logic newm;
      logic d2;
      logic mul;
      logic m2;
      logic varf;
      logic wb;
      logic avg;
      logic sqrt_step;
      logic thr;
      logic ld_out;
      logic sw;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic account;
      logic div_done;
      logic sqrt_done;
      logic n_gt1;
      logic var_nz;
      logic out_busy;
   } status_type;

endpackage

FILE: rtl/core/ptzs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ptzs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ptzs_ctrl.sv
// Sequencer of the pedestal tracker: steps one item through read, update,
// averaging, square root, output and page switch. Depends on ptzs_pkg.
module ptzs_ctrl import ptzs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [18:0] {
      S_CLEAR = 19'b000_0000_0000_0000_0001,
      S_IDLE  = 19'b000_0000_0000_0000_0010,
      S_RD    = 19'b000_0000_0000_0000_0100,
      S_CAP0  = 19'b000_0000_0000_0000_1000,
      S_CAP1  = 19'b000_0000_0000_0001_0000,
      S_UPD   = 19'b000_0000_0000_0010_0000,
      S_DIVM  = 19'b000_0000_0000_0100_0000,
      S_NEWM  = 19'b000_0000_0000_1000_0000,
      S_D2    = 19'b000_0000_0001_0000_0000,
      S_MUL   = 19'b000_0000_0010_0000_0000,
      S_M2    = 19'b000_0000_0100_0000_0000,
      S_DIVV  = 19'b000_0000_1000_0000_0000,
      S_VARF  = 19'b000_0001_0000_0000_0000,
      S_WB    = 19'b000_0010_0000_0000_0000,
      S_AVG   = 19'b000_0100_0000_0000_0000,
      S_SQRT  = 19'b000_1000_0000_0000_0000,
      S_THR   = 19'b001_0000_0000_0000_0000,
      S_OUT   = 19'b010_0000_0000_0000_0000,
      S_SW    = 19'b100_0000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clear_en = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CAP0;
         end
         S_CAP0: begin
            cmd.cap0 = 1'b1;
            state_in = S_CAP1;
         end
         S_CAP1: begin
            cmd.cap1 = 1'b1;
            state_in = status.account ? S_UPD : S_AVG;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_DIVM;
         end
         S_DIVM: begin
            if (status.div_done) begin
               state_in = S_NEWM;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_NEWM: begin
            cmd.newm = 1'b1;
            state_in = S_D2;
         end
         S_D2: begin
            cmd.d2   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.m2   = 1'b1;
            state_in = status.n_gt1 ? S_DIVV : S_WB;
         end
         S_DIVV: begin
            if (status.div_done) begin
               state_in = S_VARF;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_VARF: begin
            cmd.varf = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = S_AVG;
         end
         S_AVG: begin
            cmd.avg  = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (status.sqrt_done) begin
               state_in = S_THR;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         S_THR: begin
            cmd.thr  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // with no result to load go on at once; else hold until the output register is free
            if (!status.var_nz) begin
               state_in = S_SW;
            end else if (!status.out_busy) begin
               cmd.ld_out = 1'b1;
               state_in   = S_SW;
            end
         end
         S_SW: begin
            cmd.sw   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: rtl/core/ptzs_dp.sv
// Datapath of the pedestal tracker: page and select memories, shared divider,
// square root unit, threshold multiplier and output register. Depends on ptzs_pkg, ptzs_ram.
module ptzs_dp import ptzs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [15:0]        cutoff,
   input  logic [CH_W-1:0]    req_channel,
   input  logic [15:0]        req_sample,
   input  logic               req_account,
   input  logic               req_last_of_channel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CH_W-1:0]    rsp_out_channel,
   output logic [23:0]        rsp_sigma,
   output logic signed [32:0] rsp_excess,
   output logic               rsp_excess_valid
);

   logic [CH_W-1:0]    ch_ff;
   logic [15:0]        x_ff;
   logic               acc_ff, last_ff, sel_ff;
   page_type           p0_ff, p1_ff, p0_in, p1_in, w_pg, w_in;
   logic               dneg_ff;
   logic [31:0]        dabs_ff, d2abs_ff;
   logic [63:0]        prod_ff;
   logic [63:0]        dvd_ff;
   logic [15:0]        rem_ff, dvs_ff;
   logic [6:0]         dcnt_ff;
   logic [31:0]        mavg_ff;
   logic [47:0]        vavg_ff;
   logic [47:0]        sv_ff, sres_ff, sbit_ff;
   logic [4:0]         scnt_ff;
   logic [39:0]        thr_ff;
   logic signed [33:0] ex_ff;
   logic [PAGE_W:0]    clr_ff;
   logic               ov_ff, oexv_ff;
   logic [CH_W-1:0]    och_ff;
   logic [23:0]        osig_ff;
   logic [32:0]        oex_ff;

   logic [31:0]        x32;
   logic [33:0]        d_full;
   logic [15:0]        n_val;
   logic [16:0]        div_t;
   logic               div_ge;
   logic [64:0]        m2_sum;
   logic [63:0]        m2_new;
   logic               k2;
   logic [32:0]        msum;
   logic [48:0]        vsum;
   logic [47:0]        vavg_val;
   logic [48:0]        sq_s;
   logic               sq_ge;
   logic               ex_gt;
   logic               sw_cond;

   logic               pg_we, sel_we;
   logic [PAGE_W-1:0]  pg_waddr, pg_raddr;
   logic [PAGE_BITS-1:0] pg_wdata, pg_rdata;
   logic [CH_W-1:0]    sel_waddr;
   logic               sel_wdata, sel_rdata;

   ptzs_ram #(.WIDTH(PAGE_BITS), .DEPTH(PAGES)) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_waddr),
      .wr_data (pg_wdata),
      .rd_addr (pg_raddr),
      .rd_data (pg_rdata)
   );

   ptzs_ram #(.WIDTH(1), .DEPTH(CHANNELS)) u_sel_ram (
      .clock   (clock),
      .wr_en   (sel_we),
      .wr_addr (sel_waddr),
      .wr_data (sel_wdata),
      .rd_addr (ch_ff),
      .rd_data (sel_rdata)
   );

   assign x32  = {x_ff, 16'd0};
   assign w_pg = sel_ff ? p1_ff : p0_ff;

   always_comb begin
      w_in     = w_pg;
      d_full   = {2'b00, x32} - {2'b00, w_pg.mean};
      n_val    = (w_pg.count == 16'hFFFF) ? w_pg.count : w_pg.count + 16'd1;
      m2_sum   = {1'b0, w_pg.m2} + {17'd0, prod_ff[63:16]};
      m2_new   = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
      div_t    = {rem_ff, dvd_ff[63]};
      div_ge   = div_t >= {1'b0, dvs_ff};
      if (cmd.upd) begin
         w_in.count = n_val;
      end
      if (cmd.newm) begin
         w_in.mean = dneg_ff ? w_pg.mean - dvd_ff[31:0] : w_pg.mean + dvd_ff[31:0];
      end
      if (cmd.m2) begin
         w_in.m2 = m2_new;
      end
      if (cmd.varf) begin
         w_in.variance = (|dvd_ff[63:48]) ? M48 : dvd_ff[47:0];
      end
   end

   always_comb begin
      p0_in = p0_ff;
      p1_in = p1_ff;
      if (cmd.cap0) begin
         p0_in = page_type'(pg_rdata);
      end else if (cmd.cap1) begin
         p1_in = page_type'(pg_rdata);
      end else if (sel_ff) begin
         p1_in = w_in;
      end else begin
         p0_in = w_in;
      end
   end

   // averaging over the pages that hold samples
   always_comb begin
      k2   = (p0_ff.count != 16'd0) && (p1_ff.count != 16'd0);
      msum = {1'b0, p0_ff.mean} + {1'b0, p1_ff.mean};
      vsum = {1'b0, p0_ff.variance} + {1'b0, p1_ff.variance};
      if (k2) begin
         vavg_val = vsum[48:1];
      end else begin
         vavg_val = vsum[48] ? M48 : vsum[47:0];
      end
      sq_s  = {1'b0, sres_ff} + {1'b0, sbit_ff};
      sq_ge = {1'b0, sv_ff} >= sq_s;
      ex_gt = $signed({{7{ex_ff[33]}}, ex_ff}) > $signed({1'b0, thr_ff});
      sw_cond = last_ff && (w_pg.count >= 16'(PAGE_LIMIT));
   end

   // memory ports
   always_comb begin
      pg_we     = 1'b0;
      pg_waddr  = {ch_ff, sel_ff};
      pg_wdata  = w_pg;
      sel_we    = 1'b0;
      sel_waddr = ch_ff;
      sel_wdata = ~sel_ff;
      pg_raddr  = {ch_ff, cmd.cap0};
      if (cmd.clear_en) begin
         pg_we     = 1'b1;
         pg_waddr  = clr_ff[PAGE_W-1:0];
         pg_wdata  = '0;
         sel_we    = 1'b1;
         sel_waddr = clr_ff[CH_W-1:0];
         sel_wdata = 1'b0;
      end else if (cmd.wb) begin
         pg_we = 1'b1;
      end else if (cmd.sw && sw_cond) begin
         // flip the write page and clear the page it now points to
         pg_we    = 1'b1;
         pg_waddr = {ch_ff, ~sel_ff};
         pg_wdata = '0;
         sel_we   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      if (cmd.accept) begin
         ch_ff   <= req_channel;
         x_ff    <= req_sample;
         acc_ff  <= req_account;
         last_ff <= req_last_of_channel;
      end
      if (cmd.cap0) begin
         sel_ff <= sel_rdata;
      end
      if (cmd.upd) begin
         dneg_ff <= d_full[33];
         dabs_ff <= d_full[33] ? 32'(-d_full) : d_full[31:0];
         dvd_ff  <= {32'd0, d_full[33] ? 32'(-d_full) : d_full[31:0]};
         dvs_ff  <= n_val;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.m2) begin
         dvd_ff  <= m2_new;
         dvs_ff  <= w_pg.count - 16'd1;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= div_ge ? 16'(div_t - {1'b0, dvs_ff}) : div_t[15:0];
         dvd_ff  <= {dvd_ff[62:0], div_ge};
         dcnt_ff <= dcnt_ff + 7'd1;
      end
      if (cmd.d2) begin
         d2abs_ff <= (x32 >= w_pg.mean) ? x32 - w_pg.mean : w_pg.mean - x32;
      end
      if (cmd.mul) begin
         prod_ff <= {32'd0, dabs_ff} * {32'd0, d2abs_ff};
      end
      if (cmd.avg) begin
         mavg_ff <= k2 ? msum[32:1] : msum[31:0];
         vavg_ff <= vavg_val;
         sv_ff   <= vavg_val;
         sres_ff <= '0;
         sbit_ff <= 48'd1 << 46;
         scnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (sq_ge) begin
            sv_ff   <= sv_ff - sq_s[47:0];
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
         scnt_ff <= scnt_ff + 5'd1;
      end
      if (cmd.thr) begin
         thr_ff <= {24'd0, cutoff} * {16'd0, sres_ff[23:0]};
         ex_ff  <= $signed({2'b00, x32} - {2'b00, mavg_ff});
      end
      if (cmd.ld_out) begin
         och_ff  <= ch_ff;
         osig_ff <= sres_ff[23:0];
         oexv_ff <= ex_gt;
         oex_ff  <= ex_gt ? ex_ff[32:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.ld_out) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign status.clear_done = clr_ff[PAGE_W];
   assign status.account    = acc_ff;
   assign status.div_done   = (dcnt_ff == 7'(DIV_STEPS));
   assign status.sqrt_done  = (scnt_ff == 5'(SQRT_STEPS));
   assign status.n_gt1      = (w_pg.count > 16'd1);
   assign status.var_nz     = (vavg_ff != 48'd0);
   assign status.out_busy   = ov_ff;

   assign rsp_valid        = ov_ff;
   assign rsp_out_channel  = och_ff;
   assign rsp_sigma        = osig_ff;
   assign rsp_excess       = $signed(oex_ff);
   assign rsp_excess_valid = oexv_ff;

endmodule

FILE: rtl/core/pedestal_tracker_zero_suppress_top.sv
// Top level of the pedestal tracker with zero suppression: register port,
// sequencer and datapath. Depends on ptzs_pkg, ptzs_ctrl, ptzs_dp.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  channel, sample, account, last_of_channel
//   rsp_      out        rsp_valid/rsp_ready  out_channel, sigma, excess, excess_valid
//   csr_      in         APB write/read       cutoff at byte address 0
//
// One item at a time; an item with accounting runs the 64-step shared divider for the mean
// and, once its page holds more than one sample, again for the variance.
// After reset a clearing pass sweeps all 512 pages of the page memory before items are taken.
// A result waits in the output register; only the next result stalls on it.
module pedestal_tracker_zero_suppress_top import ptzs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_channel,
   input  logic [15:0]        req_sample,
   input  logic               req_account,
   input  logic               req_last_of_channel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_channel,
   output logic [23:0]        rsp_sigma,
   output logic signed [32:0] rsp_excess,
   output logic               rsp_excess_valid,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cmd_type     cmd;
   status_type  status;
   logic [15:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_CUTOFF_ADDR) begin
         cutoff_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_CUTOFF_ADDR) ? {16'd0, cutoff_ff} : 32'd0;

   ptzs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptzs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cutoff              (cutoff_ff),
      .req_channel         (req_channel),
      .req_sample          (req_sample),
      .req_account         (req_account),
      .req_last_of_channel (req_last_of_channel),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_sigma           (rsp_sigma),
      .rsp_excess          (rsp_excess),
      .rsp_excess_valid    (rsp_excess_valid)
   );

endmodule

FILE: dv/ptzs_checker.sv
// Scoreboard for the pedestal tracker: predicts per-channel Welford pages and compares results.
// Watches the req_, rsp_ and csr_ ports of the block; depends on ptzs_pkg.
`timescale 1ns / 1ps
module ptzs_checker import ptzs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_channel,
   input  logic [15:0]        req_sample,
   input  logic               req_account,
   input  logic               req_last_of_channel,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_out_channel,
   input  logic [23:0]        rsp_sigma,
   input  logic signed [32:0] rsp_excess,
   input  logic               rsp_excess_valid,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [7:0]  channel;
      logic [23:0] sigma;
      logic [32:0] excess;
      logic        excess_valid;
   } pedestal_result_type;

   logic [15:0] pg_count [PAGES];
   logic [31:0] pg_mean  [PAGES];
   logic [63:0] pg_m2    [PAGES];
   logic [47:0] pg_var   [PAGES];
   logic        wr_page  [CHANNELS];
   logic [15:0] cutoff_q;
   pedestal_result_type expected_results[$];

   assign pending = expected_results.size();

   function automatic logic [23:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[23:0];
   endfunction

   task automatic welford_add(int e, logic [63:0] x);
      logic [15:0] n;
      longint      d;
      longint      d2;
      logic [63:0] ad;
      logic [63:0] ad2;
      logic [63:0] prod;
      logic [64:0] sum;
      logic [63:0] v;
      n = pg_count[e];
      if (n != 16'hFFFF) n = n + 1;
      pg_count[e] = n;
      d = longint'(x) - longint'({32'd0, pg_mean[e]});
      pg_mean[e] = pg_mean[e] + 32'(d / longint'({48'd0, n}));
      d2 = longint'(x) - longint'({32'd0, pg_mean[e]});
      ad   = d < 0 ? -d : d;
      ad2  = d2 < 0 ? -d2 : d2;
      prod = (ad * ad2) >> 16;
      sum  = {1'b0, pg_m2[e]} + {1'b0, prod};
      pg_m2[e] = sum[64] ? {64{1'b1}} : sum[63:0];
      if (n > 1) begin
         v = pg_m2[e] / {48'd0, n - 16'd1};
         pg_var[e] = v > {16'd0, M48} ? M48 : v[47:0];
      end
   endtask

   task automatic predict_sample();
      int                  ch;
      int                  base;
      int                  we;
      int                  k;
      logic [63:0]         x;
      logic [63:0]         mean_avg;
      logic [63:0]         var_avg;
      logic [23:0]         sig;
      longint              ex;
      longint              thr;
      pedestal_result_type r;
      ch   = req_channel;
      x    = {32'd0, req_sample, 16'd0};
      base = ch * 2;
      we   = base + wr_page[ch];
      if (req_account) welford_add(we, x);
      k = (pg_count[base] != 0) + (pg_count[base + 1] != 0);
      if (k == 0) k = 1;
      mean_avg = ({32'd0, pg_mean[base]} + {32'd0, pg_mean[base + 1]}) / k;
      var_avg  = ({16'd0, pg_var[base]} + {16'd0, pg_var[base + 1]}) / k;
      if (var_avg > {16'd0, M48}) var_avg = {16'd0, M48};
      if (var_avg != 0) begin
         sig = int_sqrt(var_avg);
         ex  = longint'(x) - longint'(mean_avg);
         thr = longint'({48'd0, cutoff_q}) * longint'({40'd0, sig});
         r.channel      = ch[7:0];
         r.sigma        = sig;
         r.excess_valid = ex > thr;
         r.excess       = r.excess_valid ? ex[32:0] : 33'd0;
         expected_results.push_back(r);
      end
      // switch page after evaluation and clear the one now being written
      if (req_last_of_channel && pg_count[we] >= PAGE_LIMIT) begin
         wr_page[ch] = ~wr_page[ch];
         we = base + wr_page[ch];
         pg_count[we] = 0;
         pg_mean[we]  = 0;
         pg_m2[we]    = 0;
         pg_var[we]   = 0;
      end
   endtask

   task automatic compare_result();
      pedestal_result_type r;
      if (expected_results.size() == 0) begin
         $error("unexpected result on channel %0d", rsp_out_channel);
         fail_count++;
         return;
      end
      r = expected_results.pop_front();
      if (rsp_out_channel !== r.channel) begin
         $error("out_channel: expected %0d, got %0d", r.channel, rsp_out_channel);
         fail_count++;
      end
      if (rsp_sigma !== r.sigma) begin
         $error("sigma: expected %0d, got %0d", r.sigma, rsp_sigma);
         fail_count++;
      end
      if (rsp_excess !== r.excess) begin
         $error("excess: expected %0d, got %0d", $signed(r.excess), rsp_excess);
         fail_count++;
      end
      if (rsp_excess_valid !== r.excess_valid) begin
         $error("excess_valid: expected %0d, got %0d", r.excess_valid, rsp_excess_valid);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            pg_count[i] = 0;
            pg_mean[i]  = 0;
            pg_m2[i]    = 0;
            pg_var[i]   = 0;
         end
         for (int i = 0; i < CHANNELS; i++) wr_page[i] = 0;
         cutoff_q = CUTOFF_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_CUTOFF_ADDR)
            cutoff_q = csr_pwdata[15:0];
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready) predict_sample();
      end
   end

endmodule

FILE: dv/tb_pedestal_tracker_zero_suppress_top.sv
// Testbench top for the pedestal tracker: clock, reset, stimulus, flow control and verdict.
// Depends on ptzs_pkg, pedestal_tracker_zero_suppress_top and ptzs_checker.
`timescale 1ns / 1ps
module tb_pedestal_tracker_zero_suppress_top import ptzs_pkg::*;;

   localparam logic [2:0] CSR_UNMAPPED_ADDR = 3'd4;
   localparam int STALL_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_channel;
   logic [15:0]        req_sample;
   logic               req_account;
   logic               req_last_of_channel;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_out_channel;
   logic [23:0]        rsp_sigma;
   logic signed [32:0] rsp_excess;
   logic               rsp_excess_valid;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count;
   int                 pending;
   int                 gap_pct;
   int                 stall_pct;
   int                 quiet_cycles;

   pedestal_tracker_zero_suppress_top uut (.*);

   ptzs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("pedestal_tracker_zero_suppress_top regression: fail");
         $finish;
      end
   end

   task automatic push_sample(int ch, int smp, bit acc, bit lst);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_channel         <= ch[7:0];
      req_sample          <= smp[15:0];
      req_account         <= acc;
      req_last_of_channel <= lst;
      req_valid           <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      req_valid   <= 0;
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      @(posedge clock);
   endtask

   // drain every result, then let a result-free item finish before touching registers
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_sample();
      int ch;
      int smp;
      ch = ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255);
      if ($urandom_range(99) < 10)
         smp = $urandom_range(65535);
      else
         smp = 1000 + ch * 200 + $urandom_range(60) - 30;
      push_sample(ch, smp, $urandom_range(99) < 85, $urandom_range(99) < 25);
   endtask

   initial begin
      logic [15:0] cutoffs [5];
      reset = 1;
      req_valid = 0;
      req_channel = 0;
      req_sample = 0;
      req_account = 0;
      req_last_of_channel = 0;
      rsp_ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      gap_pct = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: first sample gives zero variance, then extremes and evaluate-only items
      push_sample(0, 0, 1, 0);
      push_sample(0, 65535, 1, 1);
      push_sample(0, 0, 0, 0);
      push_sample(0, 65535, 0, 1);
      push_sample(255, 65535, 1, 0);
      push_sample(255, 0, 1, 0);
      push_sample(255, 32768, 1, 1);
      push_sample(255, 65535, 0, 0);
      for (int i = 0; i < 6; i++) push_sample(1, 500 + i, 1, i == 5);
      push_sample(1, 520, 0, 0);
      push_sample(1, 400, 0, 0);
      push_sample(2, 100, 0, 0);
      settle();
      csr_write(CSR_UNMAPPED_ADDR, 32'h0000_0000);
      csr_write(CSR_CUTOFF_ADDR, 32'hFFFF_FFFF);
      push_sample(1, 65535, 0, 0);
      push_sample(0, 65535, 0, 0);
      settle();
      csr_write(CSR_CUTOFF_ADDR, 32'h0000_0000);
      push_sample(1, 503, 0, 0);
      push_sample(1, 0, 0, 1);
      push_sample(0, 40000, 1, 0);
      settle();

      // random phases over cutoff settings and flow-control modes
      cutoffs = '{16'd0, 16'd65535, 16'd768, 16'd256, 16'd0};
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_CUTOFF_ADDR, ph == 4 ? $urandom : {16'h0, cutoffs[ph]});
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 62; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase
         for (int i = 0; i < 350; i++) random_sample();
         settle();
      end

      if (fail_count == 0 && pending == 0)
         $display("pedestal_tracker_zero_suppress_top regression: pass");
      else
         $display("pedestal_tracker_zero_suppress_top regression: fail");
      $finish;
   end

endmodule
